>>> rtl/plm_pkg.sv
// shared constants, codes and cell command type for the positional list engine
package plm_pkg;

  // default sizing
  localparam int PLM_CAPACITY   = 32;
  localparam int PLM_DATA_WIDTH = 32;

  // fixed field widths of the request and response words
  localparam int REQ_W    = 2;
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  // cell index width, covers the largest supported capacity
  localparam int IDX_W = 6;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd3;

  // operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] idx;   // target slot of an insert or delete
    logic [IDX_W-1:0] tail;  // last occupied slot, for rotation
  } cell_cmd_t;

endpackage

>>> rtl/plm_req_if.sv
// request channel: valid/ready handshake carrying one request word
interface plm_req_if import plm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [POS_W-1:0]   position;
  logic [VALUE_W-1:0] value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink   (input valid, req_type, position, value, output ready);
endinterface

>>> rtl/plm_rsp_if.sv
// response channel: valid/ready handshake carrying one result word
interface plm_rsp_if import plm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  element_count;
  logic [VALUE_W-1:0]  element_value;
  logic                last;

  modport source (output valid, status, element_count, element_value, last, input ready);
  modport sink   (input valid, status, element_count, element_value, last, output ready);
endinterface

>>> rtl/positional_list_engine_top.sv
// positional list engine: ordered list kept in a chain of shifting cells
// insert and delete register their result word as they are accepted; throughput
// is one per cycle while results are taken, as the whole chain shifts at once
// a dump rotates the n elements through the head cell, one word per cycle while
// results are taken, and takes no request until the last word is loaded
// reset: element count and control clear synchronously; cells stay undefined
module positional_list_engine_top import plm_pkg::*; #(
  parameter int CAPACITY   = PLM_CAPACITY,
  parameter int DATA_WIDTH = PLM_DATA_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  plm_req_if.sink   in_ch,
  plm_rsp_if.source out_ch
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int XW   = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        dump_cnt_r, dump_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;
  logic [VALUE_W-1:0]   out_value_r, out_value_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                  out_free;
  logic                  in_ready;
  logic                  in_acc;
  logic [CMPW-1:0]       pos_ext;
  logic [CMPW-1:0]       cnt_ext;
  logic                  ins_pos_ok;
  logic                  del_pos_ok;
  logic                  list_full;
  logic                  dump_last;
  logic [XW-1:0]         in_value_ext;
  logic [DATA_WIDTH-1:0] ins_value;
  logic [XW-1:0]         head_ext;
  cell_cmd_t             cmd;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

  // handshake
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign in_acc   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // position and capacity checks
  assign pos_ext    = CMPW'(in_ch.position);
  assign cnt_ext    = CMPW'(count_r);
  assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMPW'(1));
  assign del_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign list_full  = (count_r == CW'(CAPACITY));
  assign dump_last  = (CW'(dump_cnt_r + CW'(1)) == count_r);

  // data width adaption
  assign in_value_ext = XW'(in_ch.value);
  assign ins_value    = DATA_WIDTH'(in_value_ext);
  assign head_ext     = XW'(cell_data[0]);

  // control: request decode, dump sequencing and result word loading
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    dump_cnt_nxt   = dump_cnt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    cmd.op         = OP_HOLD;
    cmd.idx        = IDX_W'(pos_ext - CMPW'(1));
    cmd.tail       = IDX_W'(cnt_ext - CMPW'(1));

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.req_type)
            REQ_INSERT: begin
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              out_last_nxt  = 1'b1;
              if (!ins_pos_ok) begin
                out_status_nxt = STAT_BADPOS;
              end else if (list_full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                out_status_nxt = STAT_OK;
                cmd.op         = OP_INSERT;
                count_nxt      = count_r + CW'(1);
              end
              out_count_nxt = COUNT_W'(count_nxt);
            end
            REQ_DELETE: begin
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              out_last_nxt  = 1'b1;
              if (!del_pos_ok) begin
                out_status_nxt = STAT_BADPOS;
              end else begin
                out_status_nxt = STAT_OK;
                cmd.op         = OP_DELETE;
                count_nxt      = count_r - CW'(1);
              end
              out_count_nxt = COUNT_W'(count_nxt);
            end
            REQ_DUMP: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_EMPTY;
                out_count_nxt  = '0;
                out_value_nxt  = '0;
                out_last_nxt   = 1'b1;
              end else begin
                state_nxt    = ST_DUMP;
                dump_cnt_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DUMP: begin
        // emit head, rotate chain so the next element reaches the head
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_count_nxt  = COUNT_W'(count_r);
          out_value_nxt  = head_ext[VALUE_W-1:0];
          out_last_nxt   = dump_last;
          cmd.op         = OP_ROTATE;
          dump_cnt_nxt   = dump_cnt_r + CW'(1);
          if (dump_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      dump_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_cnt_r  <= dump_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result word registers
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.element_count = out_count_r;
  assign out_ch.element_value = out_value_r;
  assign out_ch.last          = out_last_r;

  // chain of list cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    plm_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .ins_value  (ins_value),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (cell_data[0]),
      .data_q     (cell_data[i])
    );
  end

  // count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  // a dump only runs over a non-empty list
  a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP) |-> (count_r != '0))
    else $error("dump running on empty list");

  // a successful insert grows the list by one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.req_type == REQ_INSERT && ins_pos_ok && !list_full)
      |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow list");

  // the final dump word returns the engine to idle
  a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP && out_free && dump_last) |=> (state_r == ST_IDLE))
    else $error("dump did not end after last word");

endmodule

>>> rtl/plm_cell.sv
// one list slot: holds an element and shifts to or from its neighbours
module plm_cell import plm_pkg::*; #(
  parameter int DATA_WIDTH = PLM_DATA_WIDTH,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [DATA_WIDTH-1:0] ins_value,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [DATA_WIDTH-1:0] head_data,
  output logic [DATA_WIDTH-1:0] data_q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  // slot update per broadcast operation
  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      OP_INSERT: begin
        if (MY_IDX == cmd.idx) begin
          data_nxt = ins_value;
        end else if (MY_IDX > cmd.idx) begin
          data_nxt = left_data;
        end
      end
      OP_DELETE: begin
        if (MY_IDX >= cmd.idx) begin
          data_nxt = right_data;
        end
      end
      OP_ROTATE: begin
        if (MY_IDX < cmd.tail) begin
          data_nxt = right_data;
        end else if (MY_IDX == cmd.tail) begin
          data_nxt = head_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  // element storage, no reset needed
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

>>> dv/positional_list_engine_top_test.sv
// self-checking testbench for the positional list engine: directed rows, then random traffic
`timescale 1ns / 100ps

module positional_list_engine_top_test;
  import plm_pkg::*;

  localparam int LIST_CAP = PLM_CAPACITY;

  // the one request code the block ignores
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // one result word as the block should send it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [VALUE_W-1:0]  value;
    logic                last;
  } list_word_t;

  // one directed request, with its result typed in where it is obvious
  typedef struct packed {
    logic [REQ_W-1:0]    kind;
    logic [POS_W-1:0]    pos;
    logic [VALUE_W-1:0]  val;
    logic                typed;
    logic [STATUS_W-1:0] st;
    logic [COUNT_W-1:0]  cnt;
  } stim_row_t;

  logic clk;
  logic rst_n;

  plm_req_if req_ch ();
  plm_rsp_if rsp_ch ();

  positional_list_engine_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  // shadow copy of the list
  logic [VALUE_W-1:0] shadow_list [LIST_CAP];
  int                 shadow_len;

  list_word_t pending_words [$];
  int         mismatches;
  int         src_idle_pct;
  int         snk_idle_pct;

  stim_row_t directed_rows [17] = '{
    '{REQ_DUMP,   6'd0,  32'h0000_0000, 1'b1, STAT_EMPTY,  6'd0},
    '{REQ_DELETE, 6'd1,  32'h0000_0000, 1'b1, STAT_BADPOS, 6'd0},
    '{REQ_INSERT, 6'd0,  32'h1234_5678, 1'b1, STAT_BADPOS, 6'd0},
    '{REQ_INSERT, 6'd2,  32'h0000_0000, 1'b1, STAT_BADPOS, 6'd0},
    '{REQ_UNUSED, 6'd1,  32'hdead_beef, 1'b0, STAT_OK,     6'd0},
    '{REQ_INSERT, 6'd1,  32'hffff_ffff, 1'b1, STAT_OK,     6'd1},
    '{REQ_INSERT, 6'd1,  32'h0000_0000, 1'b1, STAT_OK,     6'd2},
    '{REQ_INSERT, 6'd3,  32'ha5a5_a5a5, 1'b1, STAT_OK,     6'd3},
    '{REQ_INSERT, 6'd2,  32'h5a5a_5a5a, 1'b1, STAT_OK,     6'd4},
    '{REQ_DUMP,   6'd63, 32'hffff_ffff, 1'b0, STAT_OK,     6'd0},
    '{REQ_INSERT, 6'd63, 32'h0000_0000, 1'b1, STAT_BADPOS, 6'd4},
    '{REQ_DELETE, 6'd0,  32'hffff_ffff, 1'b1, STAT_BADPOS, 6'd4},
    '{REQ_DELETE, 6'd5,  32'h0000_0000, 1'b1, STAT_BADPOS, 6'd4},
    '{REQ_DELETE, 6'd4,  32'h0000_0000, 1'b1, STAT_OK,     6'd3},
    '{REQ_DELETE, 6'd1,  32'h0000_0000, 1'b1, STAT_OK,     6'd2},
    '{REQ_DUMP,   6'd0,  32'h0000_0000, 1'b0, STAT_OK,     6'd0},
    '{REQ_UNUSED, 6'd63, 32'hffff_ffff, 1'b0, STAT_OK,     6'd0}
  };

  // apply one request to the shadow list, queueing its result words if asked
  function automatic void apply_list_request(input logic [REQ_W-1:0] kind,
                                             input logic [POS_W-1:0] pos,
                                             input logic [VALUE_W-1:0] val,
                                             input bit queue_words);
    int         p;
    list_word_t w;
    p = int'(pos);
    w.value = '0;
    w.last  = 1'b1;
    case (kind)
      REQ_INSERT: begin
        if (p < 1 || p > shadow_len + 1) begin
          w.status = STAT_BADPOS;
        end else if (shadow_len >= LIST_CAP) begin
          w.status = STAT_FULL;
        end else begin
          for (int i = shadow_len; i > p - 1; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p-1] = val;
          shadow_len++;
          w.status = STAT_OK;
        end
        w.count = COUNT_W'(shadow_len);
        if (queue_words) pending_words.push_back(w);
      end
      REQ_DELETE: begin
        if (p < 1 || p > shadow_len) begin
          w.status = STAT_BADPOS;
        end else begin
          for (int i = p - 1; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
          w.status = STAT_OK;
        end
        w.count = COUNT_W'(shadow_len);
        if (queue_words) pending_words.push_back(w);
      end
      REQ_DUMP: begin
        w.count = COUNT_W'(shadow_len);
        if (shadow_len == 0) begin
          w.status = STAT_EMPTY;
          if (queue_words) pending_words.push_back(w);
        end else begin
          for (int i = 0; i < shadow_len; i++) begin
            w.status = STAT_OK;
            w.value  = shadow_list[i];
            w.last   = (i == shadow_len - 1);
            if (queue_words) pending_words.push_back(w);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // value with a bias towards the extremes
  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // present one request word, with random idle gaps, and predict it once taken
  task automatic push_request(input logic [REQ_W-1:0] kind,
                              input logic [POS_W-1:0] pos,
                              input logic [VALUE_W-1:0] val,
                              input bit queue_words);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.position <= pos;
    req_ch.value    <= val;
    do @(posedge clk); while (!req_ch.ready);
    apply_list_request(kind, pos, val, queue_words);
  endtask

  // random mix of requests, mostly at positions the list can take
  task automatic send_random_mix(input int n);
    int               sent;
    int               r;
    logic [REQ_W-1:0] kind;
    logic [POS_W-1:0] pos;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 5) kind = REQ_UNUSED;
      else if (r < 50) kind = REQ_INSERT;
      else if (r < 85) kind = REQ_DELETE;
      else kind = REQ_DUMP;
      if ($urandom_range(9) < 8 && kind == REQ_INSERT)
        pos = POS_W'($urandom_range(shadow_len + 1, 1));
      else if ($urandom_range(9) < 8 && kind == REQ_DELETE && shadow_len > 0)
        pos = POS_W'($urandom_range(shadow_len, 1));
      else
        pos = POS_W'($urandom_range(63));
      push_request(kind, pos, pick_value(), 1'b1);
      if (kind != REQ_UNUSED) sent++;
    end
  endtask

  // fill to capacity, probe the full list, dump it and drain part of it
  task automatic fill_and_probe();
    while (shadow_len < LIST_CAP)
      push_request(REQ_INSERT, POS_W'($urandom_range(shadow_len + 1, 1)), pick_value(), 1'b1);
    push_request(REQ_INSERT, POS_W'(1), pick_value(), 1'b1);
    push_request(REQ_INSERT, POS_W'(LIST_CAP + 1), pick_value(), 1'b1);
    push_request(REQ_INSERT, POS_W'(LIST_CAP + 2), pick_value(), 1'b1);
    push_request(REQ_DELETE, POS_W'(LIST_CAP + 1), pick_value(), 1'b1);
    push_request(REQ_DUMP, POS_W'($urandom_range(63)), pick_value(), 1'b1);
    repeat (12)
      push_request(REQ_DELETE, POS_W'($urandom_range(shadow_len, 1)), pick_value(), 1'b1);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random back-pressure and word check
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word status %0d count %0d value %h last %b", $time,
                   rsp_ch.status, rsp_ch.element_count, rsp_ch.element_value, rsp_ch.last);
          mismatches++;
        end else begin
          if (rsp_ch.status !== pending_words[0].status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     pending_words[0].status, rsp_ch.status);
            mismatches++;
          end
          if (rsp_ch.element_count !== pending_words[0].count) begin
            $display("%0t: element_count expected %0d actual %0d", $time,
                     pending_words[0].count, rsp_ch.element_count);
            mismatches++;
          end
          if (rsp_ch.element_value !== pending_words[0].value) begin
            $display("%0t: element_value expected %h actual %h", $time,
                     pending_words[0].value, rsp_ch.element_value);
            mismatches++;
          end
          if (rsp_ch.last !== pending_words[0].last) begin
            $display("%0t: last expected %b actual %b", $time,
                     pending_words[0].last, rsp_ch.last);
            mismatches++;
          end
          void'(pending_words.pop_front());
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    list_word_t typed_word;
    mismatches      = 0;
    shadow_len      = 0;
    src_idle_pct    = 21;
    snk_idle_pct    = 53;
    rst_n           = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_INSERT;
    req_ch.position = '0;
    req_ch.value    = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    foreach (directed_rows[i]) begin
      push_request(directed_rows[i].kind, directed_rows[i].pos, directed_rows[i].val,
                   !directed_rows[i].typed);
      if (directed_rows[i].typed) begin
        typed_word.status = directed_rows[i].st;
        typed_word.count  = directed_rows[i].cnt;
        typed_word.value  = '0;
        typed_word.last   = 1'b1;
        pending_words.push_back(typed_word);
      end
    end

    // random part, sender idling lightly and receiver heavily
    fill_and_probe();
    send_random_mix(12);

    // receiver idling lightly and sender heavily
    src_idle_pct = 53;
    snk_idle_pct = 21;
    send_random_mix(12);

    // no idling on either side
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_random_mix(12);

    req_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
rtl/plm_pkg.sv
rtl/plm_req_if.sv
rtl/plm_rsp_if.sv
rtl/plm_cell.sv
rtl/positional_list_engine_top.sv
dv/positional_list_engine_top_test.sv
